// File: design/first_seen_index_renumber_assert.svh
// ----------------------------------------------------------------------------
// first_seen_index_renumber_assert.svh
// assertion macros shared by the renumbering block
// ----------------------------------------------------------------------------
`ifndef FIRST_SEEN_INDEX_RENUMBER_ASSERT_SVH
`define FIRST_SEEN_INDEX_RENUMBER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define FSIR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define FSIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fsir_pkg.sv
// ----------------------------------------------------------------------------
// fsir_pkg
// types and constants for the first-seen index renumbering block
// ----------------------------------------------------------------------------
`default_nettype none

package fsir_pkg;

  // table geometry
  localparam int unsigned MAX_VERTICES = 4096;
  localparam int unsigned ADDR_W       = $clog2(MAX_VERTICES);
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned CNT_W        = 13;
  localparam int unsigned TAG_W        = 8;

  // register reset value
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 13'd4096;

  // pass tag written by the clearing sweep, never live
  localparam logic [TAG_W-1:0] TAG_NONE  = '0;
  localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] TAG_LAST  = '1;

  typedef enum logic {
    ACT_REF    = 1'b0,
    ACT_FINISH = 1'b1
  } fsir_action_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_RANGE   = 2'd1,
    STATUS_UNRENUM = 2'd2
  } fsir_status_e;

  // input beat
  typedef struct packed {
    fsir_action_e     action;
    logic [IDX_W-1:0] old_index;
  } fsir_in_t;

  // result beat
  typedef struct packed {
    logic [IDX_W-1:0] new_index;
    logic             first_seen;
    fsir_status_e     status;
    logic [CNT_W-1:0] renumbered_count;
  } fsir_out_t;

  // one table entry: pass tag plus assigned new index
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] new_index;
  } fsir_entry_t;

  // write request into the table
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    fsir_entry_t       data;
  } fsir_wr_t;

endpackage

`default_nettype wire

// File: design/fsir_entry_ram.sv
// ----------------------------------------------------------------------------
// fsir_entry_ram
// single-port-write, single-port-read table of tagged index entries
// ----------------------------------------------------------------------------
`default_nettype none

module fsir_entry_ram (
  input  wire                          clk_i,
  input  fsir_pkg::fsir_wr_t           wr_i,
  input  wire                          rd_en_i,
  input  wire [fsir_pkg::ADDR_W-1:0]   rd_addr_i,
  output fsir_pkg::fsir_entry_t        rd_data_o
);

  fsir_pkg::fsir_entry_t mem_q [fsir_pkg::MAX_VERTICES];
  fsir_pkg::fsir_entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port, data in the cycle after rd_en_i
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: design/first_seen_index_renumber.sv
// ----------------------------------------------------------------------------
// first_seen_index_renumber
// assigns new vertex indices in order of first reference
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: item_i is taken at a rising edge with start high and busy low.
//   A reference (action 0) returns the new index of old_index, assigning
//   the next free one on first sight (first_seen 1). A finish (action 1)
//   reports whether the count reached the vertex count (capped at the table depth), then starts a new pass.
//   Result beat: result_o is shown for exactly one cycle with result_valid_o
//   high, registered after the lookup state; the receiver cannot stall it.
//   Beats do not overlap: a new one is taken only after the last lookup,
//   set by the read-modify-write of the entry table (read, compute, write).
//   Seen state is a pass tag stored with each entry; a finish moves to the
//   next tag. After reset, and after every 255th finish when the tag wraps,
//   a clearing sweep over all 4096 entries runs with busy high.
//   Config: cfg_wdata_i is written to vertex_count on any edge with cfg_we_i;
//   write it only while the block is idle. Reset value is 4096.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_seen_index_renumber_assert.svh"

module first_seen_index_renumber (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  fsir_pkg::fsir_in_t           item_i,
  output logic                         result_valid_o,
  output fsir_pkg::fsir_out_t          result_o,
  input  wire                          cfg_we_i,
  input  wire [fsir_pkg::CNT_W-1:0]    cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e                         state_q, state_d;
  logic [fsir_pkg::ADDR_W-1:0]    clr_addr_q, clr_addr_d;
  logic [fsir_pkg::TAG_W-1:0]     epoch_q, epoch_d;
  logic [fsir_pkg::CNT_W-1:0]     count_q, count_d;
  logic [fsir_pkg::CNT_W-1:0]     vertex_count_q;
  fsir_pkg::fsir_in_t             item_q, item_d;
  fsir_pkg::fsir_out_t            result_q, result_d;
  logic                           result_valid_q, result_valid_d;

  fsir_pkg::fsir_wr_t             wr;
  fsir_pkg::fsir_entry_t          rd_data;
  logic                           accept;
  logic [fsir_pkg::CNT_W-1:0]     depth;
  logic [fsir_pkg::CNT_W-1:0]     limit;
  logic                           in_range;
  logic                           seen;
  logic                           in_lookup;
  logic                           first_beat;
  logic [fsir_pkg::CNT_W-1:0]     first_next;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= fsir_pkg::VERTEX_COUNT_RST;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  // entry table
  fsir_entry_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (accept),
    .rd_addr_i (item_i.old_index),
    .rd_data_o (rd_data)
  );

  // effective limit, saturated at table depth
  assign depth = fsir_pkg::CNT_W'(fsir_pkg::MAX_VERTICES);

  always_comb begin
    if (vertex_count_q > depth) begin
      limit = depth;
    end else begin
      limit = vertex_count_q;
    end
  end

  assign in_range = fsir_pkg::CNT_W'(item_q.old_index) < limit;
  assign seen     = (rd_data.tag == epoch_q);

  // next state, table write and result
  always_comb begin
    state_d        = state_q;
    clr_addr_d     = clr_addr_q;
    epoch_d        = epoch_q;
    count_d        = count_q;
    item_d         = item_q;
    result_d       = result_q;
    result_valid_d = 1'b0;
    wr.en          = 1'b0;
    wr.addr        = item_q.old_index;
    wr.data.tag    = epoch_q;
    wr.data.new_index = count_q[fsir_pkg::IDX_W-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        wr.en       = 1'b1;
        wr.addr     = clr_addr_q;
        wr.data.tag = fsir_pkg::TAG_NONE;
        clr_addr_d  = clr_addr_q + fsir_pkg::ADDR_W'(1);
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          item_d  = item_i;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        result_valid_d            = 1'b1;
        result_d.new_index        = '0;
        result_d.first_seen       = 1'b0;
        result_d.status           = fsir_pkg::STATUS_OK;
        result_d.renumbered_count = count_q;
        state_d                   = ST_IDLE;
        if (item_q.action == fsir_pkg::ACT_FINISH) begin
          // report, then open a new pass under the next tag
          if (count_q != limit) begin
            result_d.status = fsir_pkg::STATUS_UNRENUM;
          end
          count_d = '0;
          if (epoch_q == fsir_pkg::TAG_LAST) begin
            epoch_d    = fsir_pkg::TAG_FIRST;
            clr_addr_d = '0;
            state_d    = ST_CLEAR;
          end else begin
            epoch_d = epoch_q + fsir_pkg::TAG_W'(1);
          end
        end else if (!in_range) begin
          result_d.status = fsir_pkg::STATUS_RANGE;
        end else if (seen) begin
          result_d.new_index = rd_data.new_index;
        end else begin
          // first reference in this pass: assign the next index
          wr.en                     = 1'b1;
          result_d.new_index        = count_q[fsir_pkg::IDX_W-1:0];
          result_d.first_seen       = 1'b1;
          count_d                   = count_q + fsir_pkg::CNT_W'(1);
          result_d.renumbered_count = count_q + fsir_pkg::CNT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_addr_q     <= '0;
      epoch_q        <= fsir_pkg::TAG_FIRST;
      count_q        <= '0;
      item_q         <= '0;
      result_q       <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_addr_q     <= clr_addr_d;
      epoch_q        <= epoch_d;
      count_q        <= count_d;
      item_q         <= item_d;
      result_q       <= result_d;
      result_valid_q <= result_valid_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // terms for the checks
  assign in_lookup  = (state_q == ST_LOOKUP);
  assign first_beat = result_valid_q && result_q.first_seen;
  assign first_next = fsir_pkg::CNT_W'(result_q.new_index) + fsir_pkg::CNT_W'(1);

  // checks
  `FSIR_ASSERT_SAME(a_result_src, result_valid_q, $past(in_lookup), "result without lookup")
  `FSIR_ASSERT_SAME(a_live_tag, 1'b1, epoch_q != fsir_pkg::TAG_NONE, "pass tag is the cleared tag")
  `FSIR_ASSERT_SAME(a_count_bound, 1'b1, count_q <= depth, "count beyond table depth")
  `FSIR_ASSERT_SAME(a_first_count, first_beat, count_q == first_next, "first-seen index off count")
  `FSIR_ASSERT_NEXT(a_write_first, in_lookup && wr.en, first_beat, "write without first-seen beat")

endmodule

`default_nettype wire
